[sv/vid_pkg.sv]
// vid_pkg: shared constants, types and hash function for the vertex index dedup block.
// Depends on nothing; every other file of the block uses it by scoped names.

package vid_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int TABLE_SLOTS  = 8192;   // power of two: home slot is a bit mask of the hash
   localparam int INDEX_BITS   = 21;

   localparam int FUNC_W   = 2;
   localparam int FIELD_W  = 21;
   localparam int VNUM_W   = 12;
   localparam int STATUS_W = 3;
   localparam int VCNT_W   = 13;

   localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
   localparam int NUM_BITS   = $clog2(MAX_VERTICES);
   localparam int COUNT_BITS = $clog2(MAX_VERTICES + 1);
   localparam int KEY_W      = 3 * INDEX_BITS;

   localparam logic [31:0] HASH_GOLDEN = 32'h9e37_79b9;

   typedef enum logic [FUNC_W-1:0] {
      FN_CORNER = 2'd0,
      FN_CLEAR  = 2'd1,
      FN_FINISH = 2'd2,
      FN_NOP    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED  = 3'd0,
      ST_NEW     = 3'd1,
      ST_FULL    = 3'd2,
      ST_DONE    = 3'd3,
      ST_NO_GEOM = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_MIX1,
      S_MIX2,
      S_PROBE,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_W-1:0]      key;
      logic [NUM_BITS-1:0]   number;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       mix_nrm;
      logic       mix_tex;
      logic       probe_adv;
      logic       insert;
      logic       sweep_init;
      logic       sweep_step;
      logic       clear_state;
      logic       res_load;
      status_type res_status;
      logic       res_take_num;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     seen;
      logic     hit;
      logic     empty;
      logic     count_full;
      logic     probe_last;
      logic     sweep_last;
      logic     rsp_free;
   } stat_type;

   function automatic logic [31:0] mix_step(input logic [31:0] seed, input logic [31:0] v);
      mix_step = seed ^ (v + HASH_GOLDEN + (seed << 6) + (seed >> 2));
   endfunction

endpackage

[sv/vid_if.sv]
// vid_req_if / vid_rsp_if: valid-ready channels for corner items and their results.
// Depends on vid_pkg for field widths.

interface vid_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [vid_pkg::FUNC_W-1:0]           func;
   logic signed [vid_pkg::FIELD_W-1:0]   position_index;
   logic signed [vid_pkg::FIELD_W-1:0]   nrm_index;
   logic signed [vid_pkg::FIELD_W-1:0]   tex_index;

   modport source(output valid, func, position_index, nrm_index, tex_index,
                  input ready);
   modport sink(input valid, func, position_index, nrm_index, tex_index,
                output ready);
endinterface

interface vid_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vid_pkg::VNUM_W-1:0]       vertex_number;
   logic [vid_pkg::STATUS_W-1:0]     status;
   logic [vid_pkg::VCNT_W-1:0]       vertex_count;

   modport source(output valid, vertex_number, status, vertex_count, input ready);
   modport sink(input valid, vertex_number, status, vertex_count, output ready);
endinterface

[sv/vid_ctrl.sv]
// vid_ctrl: state machine sequencing hash, probe, insert, result and table sweep.
// Depends on vid_pkg; drives vid_datapath through cmd_type, reads stat_type.

module vid_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [vid_pkg::FUNC_W-1:0]    req_func,
   output logic                          req_ready,
   input  vid_pkg::stat_type             stat,
   output vid_pkg::cmd_type              cmd,
   output vid_pkg::state_type            state
);

   vid_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vid_pkg::S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state     = state_ff;
   assign req_ready = (state_ff == vid_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         vid_pkg::S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) state_in = vid_pkg::S_IDLE;
         end
         vid_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (vid_pkg::func_type'(req_func))
                  vid_pkg::FN_CORNER: begin
                     state_in = vid_pkg::S_MIX1;
                  end
                  vid_pkg::FN_CLEAR: begin
                     cmd.clear_state = 1'b1;
                     cmd.res_load    = 1'b1;
                     cmd.res_status  = vid_pkg::ST_REUSED;
                     state_in        = vid_pkg::S_EMIT;
                  end
                  vid_pkg::FN_FINISH: begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = stat.seen ? vid_pkg::ST_DONE : vid_pkg::ST_NO_GEOM;
                     state_in       = vid_pkg::S_EMIT;
                  end
                  vid_pkg::FN_NOP: begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = vid_pkg::ST_REUSED;
                     state_in       = vid_pkg::S_EMIT;
                  end
                  default: state_in = vid_pkg::S_IDLE;
               endcase
            end
         end
         vid_pkg::S_MIX1: begin
            cmd.mix_nrm = 1'b1;
            state_in    = vid_pkg::S_MIX2;
         end
         vid_pkg::S_MIX2: begin
            cmd.mix_tex = 1'b1;
            state_in    = vid_pkg::S_PROBE;
         end
         vid_pkg::S_PROBE: begin
            state_in = vid_pkg::S_CHECK;
         end
         vid_pkg::S_CHECK: begin
            priority if (stat.hit) begin
               cmd.res_load     = 1'b1;
               cmd.res_status   = vid_pkg::ST_REUSED;
               cmd.res_take_num = 1'b1;
               state_in         = vid_pkg::S_EMIT;
            end else if (stat.empty) begin
               cmd.res_load = 1'b1;
               if (stat.count_full) begin
                  cmd.res_status = vid_pkg::ST_FULL;
               end else begin
                  cmd.insert       = 1'b1;
                  cmd.res_status   = vid_pkg::ST_NEW;
                  cmd.res_take_num = 1'b1;
               end
               state_in = vid_pkg::S_EMIT;
            end else if (stat.probe_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = vid_pkg::ST_FULL;
               state_in       = vid_pkg::S_EMIT;
            end else begin
               cmd.probe_adv = 1'b1;
               state_in      = vid_pkg::S_PROBE;
            end
         end
         vid_pkg::S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               // a clear empties the table after its result goes out
               if (stat.func == vid_pkg::FN_CLEAR) begin
                  cmd.sweep_init = 1'b1;
                  state_in       = vid_pkg::S_SWEEP;
               end else begin
                  state_in = vid_pkg::S_IDLE;
               end
            end
         end
         default: state_in = vid_pkg::S_SWEEP;
      endcase
   end

endmodule

[sv/vid_datapath.sv]
// vid_datapath: key and hash registers, slot table memory, counters and result register.
// Depends on vid_pkg; commanded by vid_ctrl.

module vid_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  vid_pkg::cmd_type                    cmd,
   output vid_pkg::stat_type                   stat,
   input  logic [vid_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [vid_pkg::FIELD_W-1:0]  req_position_index,
   input  logic signed [vid_pkg::FIELD_W-1:0]  req_nrm_index,
   input  logic signed [vid_pkg::FIELD_W-1:0]  req_tex_index,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [vid_pkg::VNUM_W-1:0]          rsp_vertex_number,
   output logic [vid_pkg::STATUS_W-1:0]        rsp_status,
   output logic [vid_pkg::VCNT_W-1:0]          rsp_vertex_count
);

   vid_pkg::entry_type mem [vid_pkg::TABLE_SLOTS];

   vid_pkg::func_type                   func_ff;
   logic [vid_pkg::INDEX_BITS-1:0]      pos_ff, nrm_ff, tex_ff;
   logic [31:0]                         hash_ff;
   logic [vid_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic [vid_pkg::SLOT_BITS-1:0]       probes_ff;
   logic [vid_pkg::COUNT_BITS-1:0]      next_number_ff;
   logic                                seen_ff;
   vid_pkg::entry_type                  rd_ff;
   vid_pkg::entry_type                  wr_data;
   logic                                wr_en;
   logic [vid_pkg::INDEX_BITS-1:0]      pos_in;
   logic [31:0]                         tex_hash;
   vid_pkg::status_type                 res_status_ff;
   logic [vid_pkg::NUM_BITS-1:0]        res_num_ff;
   logic                                rsp_valid_ff;
   logic [vid_pkg::VNUM_W-1:0]          rsp_num_ff;
   logic [vid_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [vid_pkg::VCNT_W-1:0]          rsp_count_ff;

   assign pos_in   = vid_pkg::INDEX_BITS'(req_position_index);
   assign tex_hash = vid_pkg::mix_step(hash_ff, 32'(tex_ff));
   assign slot_in  = (slot_ff == vid_pkg::SLOT_BITS'(vid_pkg::TABLE_SLOTS - 1)) ?
                     '0 : slot_ff + 1'b1;

   // item capture, hash chain with one mix step per cycle, and probe counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= vid_pkg::func_type'(req_func);
         pos_ff  <= pos_in;
         nrm_ff  <= vid_pkg::INDEX_BITS'(req_nrm_index);
         tex_ff  <= vid_pkg::INDEX_BITS'(req_tex_index);
         hash_ff <= vid_pkg::mix_step(32'd0, 32'(pos_in));
      end else if (cmd.mix_nrm) begin
         hash_ff <= vid_pkg::mix_step(hash_ff, 32'(nrm_ff));
      end
      if (cmd.mix_tex) begin
         probes_ff <= '0;
      end else if (cmd.probe_adv) begin
         probes_ff <= probes_ff + 1'b1;
      end
   end

   // slot pointer doubles as the sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.sweep_init) begin
         slot_ff <= '0;
      end else if (cmd.mix_tex) begin
         slot_ff <= tex_hash[vid_pkg::SLOT_BITS-1:0];
      end else if (cmd.probe_adv || cmd.sweep_step) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_number_ff <= '0;
         seen_ff        <= 1'b0;
      end else if (cmd.clear_state) begin
         next_number_ff <= '0;
         seen_ff        <= 1'b0;
      end else begin
         if (cmd.insert) next_number_ff <= next_number_ff + 1'b1;
         if (cmd.load && vid_pkg::func_type'(req_func) == vid_pkg::FN_CORNER) seen_ff <= 1'b1;
      end
   end

   always_comb begin
      wr_en   = cmd.sweep_step || cmd.insert;
      wr_data = '0;
      if (cmd.insert) begin
         wr_data.valid  = 1'b1;
         wr_data.key    = {pos_ff, nrm_ff, tex_ff};
         wr_data.number = vid_pkg::NUM_BITS'(next_number_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[slot_ff] <= wr_data;
      rd_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         if (!cmd.res_take_num) begin
            res_num_ff <= '0;
         end else if (cmd.res_status == vid_pkg::ST_NEW) begin
            res_num_ff <= vid_pkg::NUM_BITS'(next_number_ff);
         end else begin
            res_num_ff <= rd_ff.number;
         end
      end
   end

   // output register: holds the result until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_num_ff    <= vid_pkg::VNUM_W'(res_num_ff);
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= (res_status_ff == vid_pkg::ST_NO_GEOM) ?
                          '0 : vid_pkg::VCNT_W'(next_number_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_number = rsp_num_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_vertex_count  = rsp_count_ff;

   always_comb begin
      stat            = '0;
      stat.func       = func_ff;
      stat.seen       = seen_ff;
      stat.hit        = rd_ff.valid && (rd_ff.key == {pos_ff, nrm_ff, tex_ff});
      stat.empty      = !rd_ff.valid;
      stat.count_full = next_number_ff >= vid_pkg::COUNT_BITS'(vid_pkg::MAX_VERTICES);
      stat.probe_last = probes_ff == vid_pkg::SLOT_BITS'(vid_pkg::TABLE_SLOTS - 1);
      stat.sweep_last = slot_ff == vid_pkg::SLOT_BITS'(vid_pkg::TABLE_SLOTS - 1);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

[sv/vertex_index_dedup.sv]
// vertex_index_dedup: top level joining controller and datapath to the channels.
// Depends on vid_pkg, vid_if, vid_ctrl and vid_datapath.
//
// Usage: req_ch carries one item per handshake: func selects corner lookup-insert,
// clear, finish or no-op; the three indices form the corner key. rsp_ch returns
// exactly one item per request: vertex number, status and vertex count.
// Sequence: a corner is accepted in S_IDLE, which also mixes the position index,
// then S_MIX1 and S_MIX2 mix the other two indices, S_PROBE and S_CHECK run for
// each probed slot (single-port table read, registered), and S_EMIT loads the
// result into the output register. Clear, finish and no-op go straight to S_EMIT.
// Throughput: one item at a time; the next item is accepted once the previous
// one has loaded the output register.
// A clear returns its result, then sweeps the 8192-slot table one slot per
// cycle before the next item is accepted.
// Reset: synchronous, active high; after reset the same table sweep runs
// with req_ch.ready low. A stalled rsp_ch holds its item; one more item may be
// accepted and worked on, and waits before its result until the output frees.

module vertex_index_dedup (
   input  logic       clock,
   input  logic       reset,
   vid_req_if.sink    req_ch,
   vid_rsp_if.source  rsp_ch
);

   vid_pkg::cmd_type   cmd;
   vid_pkg::stat_type  stat;
   vid_pkg::state_type state;

   vid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   vid_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_ch.func),
      .req_position_index (req_ch.position_index),
      .req_nrm_index      (req_ch.nrm_index),
      .req_tex_index      (req_ch.tex_index),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_vertex_number  (rsp_ch.vertex_number),
      .rsp_status         (rsp_ch.status),
      .rsp_vertex_count   (rsp_ch.vertex_count)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("item accepted while previous one in flight");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == vid_pkg::ST_NEW |->
         rsp_ch.vertex_count == vid_pkg::VCNT_W'(rsp_ch.vertex_number) + 1'b1)
      else $error("new vertex number does not match count");

   a_no_geom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == vid_pkg::ST_NO_GEOM |->
         rsp_ch.vertex_count == '0 && rsp_ch.vertex_number == '0)
      else $error("no-geometry result carries nonzero fields");

   a_insert_below_max: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !stat.count_full && state == vid_pkg::S_CHECK)
      else $error("insert past vertex limit");

endmodule
